FILE: rtl/cpcl_pkg.sv
// shared types, widths and constants of the chassis power current limiter
package cpcl_pkg;

    localparam int IN_LANES        = 4;
    localparam int DEF_MOTOR_LANES = 4;
    localparam int CMD_W           = 16;
    localparam int SUM_W           = 18;
    localparam int BUD_W           = 18;
    localparam int BASE_W          = 17;
    localparam int BNUM_W          = 33;
    localparam int BDEN_W          = 16;
    localparam int BQUO_W          = 19;
    localparam int LNUM_W          = 34;
    localparam int LDEN_W          = 19;
    localparam int LQUO_W          = 15;
    localparam int QUEUE_DEPTH     = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 17;

    localparam logic [15:0]      FLOOR_BUFFER = 16'd320;
    localparam logic [BUD_W-1:0] BUDGET_MAX   = 18'd262142;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_BUFFER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_KNEE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_CEILING  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BUDGET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_BUDGET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_COUNT    = 3'd5;

    typedef logic signed [CMD_W-1:0] cmd_t;
    typedef cmd_t [IN_LANES-1:0] cmd_vec_t;

    typedef struct packed {
        logic [15:0] warning_buffer;
        logic [15:0] power_knee;
        logic [15:0] power_ceiling;
        logic [16:0] buffer_current_budget;
        logic [16:0] power_current_budget;
        logic [2:0]  motor_count;
    } cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        logic              on;
        logic [BASE_W-1:0] base;
        logic [BNUM_W-1:0] num;
        logic [BDEN_W-1:0] den;
        cmd_vec_t          cmds;
        logic [SUM_W-1:0]  sum;
    } item_t;

    // carried alongside the budget divider
    typedef struct packed {
        logic              on;
        logic              ovf;
        logic [BASE_W-1:0] base;
        cmd_vec_t          cmds;
        logic [SUM_W-1:0]  sum;
    } bside_t;

    // carried alongside the lane dividers
    typedef struct packed {
        logic             scaled;
        logic [BUD_W-1:0] budget;
        cmd_vec_t         cmds;
    } lside_t;

endpackage

FILE: rtl/cpcl_front.sv
// front part: takes a word, masks lanes, sums magnitudes, sets up the budget division
module cpcl_front #(
    parameter int MOTOR_LANES = cpcl_pkg::DEF_MOTOR_LANES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cpcl_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               limiter_on,
    input  logic [15:0]        measured_power,
    input  logic [15:0]        buffer_energy,
    input  cpcl_pkg::cmd_vec_t cmds,
    output logic               item_valid,
    input  logic               item_ready,
    output cpcl_pkg::item_t    item
);

    localparam int HW_LANES = (MOTOR_LANES < cpcl_pkg::IN_LANES) ?
                              MOTOR_LANES : cpcl_pkg::IN_LANES;

    logic                          valid_reg;
    cpcl_pkg::item_t               item_reg;
    cpcl_pkg::item_t               item_next;
    logic [2:0]                    lanes;
    logic [15:0]                   mag [cpcl_pkg::IN_LANES];
    logic [16:0]                   mul_a;
    logic [15:0]                   mul_b;
    logic                          adv;

    assign adv      = !valid_reg || item_ready;
    assign in_ready = adv;

    // lanes in use, saturated to the hardware lanes
    assign lanes = (cfg.motor_count > 3'(HW_LANES)) ? 3'(HW_LANES) : cfg.motor_count;

    // mask unused lanes, add up magnitudes and pick the budget case
    always_comb
    begin
        item_next.sum = '0;
        for (int k = 0; k < cpcl_pkg::IN_LANES; k++)
        begin
            item_next.cmds[k] = (3'(k) < lanes) ? cmds[k] : '0;
            mag[k] = item_next.cmds[k][15] ? 16'(-item_next.cmds[k]) : item_next.cmds[k];
            item_next.sum = item_next.sum + cpcl_pkg::SUM_W'(mag[k]);
        end

        item_next.on = limiter_on;
        mul_a = 17'd0;
        mul_b = 16'd1;
        item_next.den  = 16'd1;
        item_next.base = cfg.buffer_current_budget;
        if (buffer_energy < cfg.warning_buffer)
        begin
            mul_a = cfg.buffer_current_budget;
            mul_b = (buffer_energy > cpcl_pkg::FLOOR_BUFFER) ? buffer_energy :
                    cpcl_pkg::FLOOR_BUFFER;
            item_next.den  = cfg.warning_buffer;
            item_next.base = '0;
        end
        else if (measured_power <= cfg.power_knee)
        begin
            mul_a = cfg.power_current_budget;
        end
        else if (measured_power < cfg.power_ceiling)
        begin
            mul_a = cfg.power_current_budget;
            mul_b = cfg.power_ceiling - measured_power;
            item_next.den = cfg.power_ceiling - cfg.power_knee;
        end
        item_next.num = cpcl_pkg::BNUM_W'(mul_a) * cpcl_pkg::BNUM_W'(mul_b);
    end

    // front register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/cpcl_queue.sv
// short word queue between front and back
module cpcl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  cpcl_pkg::item_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output cpcl_pkg::item_t pop_data
);

    localparam int DEPTH = cpcl_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    cpcl_pkg::item_t mem [DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   rd_reg;
    logic [AW:0]     count_reg;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue fill count past depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == (AW+1)'(DEPTH)) |-> wr_reg == rd_reg)
        else $error("queue pointers disagree with fill count");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

FILE: rtl/cpcl_div.sv
// pipelined restoring divider, one quotient bit per stage, several lanes
module cpcl_div #(
    parameter int LANES  = 1,
    parameter int NUM_W  = 33,
    parameter int DEN_W  = 16,
    parameter int QUO_W  = 19,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num [LANES],
    input  logic [DEN_W-1:0]  den [LANES],
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo [LANES],
    output logic [SIDE_W-1:0] side_out
);

    logic              v_reg    [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic [DEN_W-1:0]  rem_reg  [QUO_W][LANES];
    logic [QUO_W-1:0]  low_reg  [QUO_W][LANES];
    logic [QUO_W-1:0]  q_reg    [QUO_W][LANES];
    logic [DEN_W-1:0]  den_reg  [QUO_W][LANES];

    logic              v_src    [QUO_W];
    logic [SIDE_W-1:0] side_src [QUO_W];
    logic [DEN_W-1:0]  rem_src  [QUO_W][LANES];
    logic [QUO_W-1:0]  low_src  [QUO_W][LANES];
    logic [QUO_W-1:0]  q_src    [QUO_W][LANES];
    logic [DEN_W-1:0]  den_src  [QUO_W][LANES];

    logic [DEN_W:0]    trial    [QUO_W][LANES];
    logic              ge       [QUO_W][LANES];
    logic [DEN_W-1:0]  rem_nx   [QUO_W][LANES];

    // stage sources: ports for the first stage, previous stage otherwise
    always_comb
    begin
        v_src[0]    = in_valid;
        side_src[0] = side;
        for (int l = 0; l < LANES; l++)
        begin
            rem_src[0][l] = DEN_W'(num[l][NUM_W-1:QUO_W]);
            low_src[0][l] = num[l][QUO_W-1:0];
            q_src[0][l]   = '0;
            den_src[0][l] = den[l];
        end
        for (int s = 1; s < QUO_W; s++)
        begin
            v_src[s]    = v_reg[s-1];
            side_src[s] = side_reg[s-1];
            for (int l = 0; l < LANES; l++)
            begin
                rem_src[s][l] = rem_reg[s-1][l];
                low_src[s][l] = low_reg[s-1][l];
                q_src[s][l]   = q_reg[s-1][l];
                den_src[s][l] = den_reg[s-1][l];
            end
        end
    end

    // one trial subtraction per stage and lane
    always_comb
    begin
        for (int s = 0; s < QUO_W; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[s][l]  = {rem_src[s][l], low_src[s][l][QUO_W-1]};
                ge[s][l]     = (trial[s][l] >= {1'b0, den_src[s][l]});
                rem_nx[s][l] = ge[s][l] ? DEN_W'(trial[s][l] - {1'b0, den_src[s][l]}) :
                               trial[s][l][DEN_W-1:0];
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QUO_W; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            for (int s = 0; s < QUO_W; s++)
                v_reg[s] <= v_src[s];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < QUO_W; s++)
            begin
                side_reg[s] <= side_src[s];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= rem_nx[s][l];
                    low_reg[s][l] <= {low_src[s][l][QUO_W-2:0], 1'b0};
                    q_reg[s][l]   <= {q_src[s][l][QUO_W-2:0], ge[s][l]};
                    den_reg[s][l] <= den_src[s][l];
                end
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            quo[l] = q_reg[QUO_W-1][l];
    end

endmodule

FILE: rtl/cpcl_back.sv
// back part: budget division, compare, lane scaling and output register
module cpcl_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  cpcl_pkg::item_t             item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cpcl_pkg::cmd_vec_t          limited,
    output logic                        scaling_applied,
    output logic [cpcl_pkg::BUD_W-1:0]  current_budget
);

    localparam int L = cpcl_pkg::IN_LANES;

    logic                          adv;
    cpcl_pkg::bside_t              bside_in;
    cpcl_pkg::bside_t              bside_out;
    logic [cpcl_pkg::BNUM_W-1:0]   bnum [1];
    logic [cpcl_pkg::BDEN_W-1:0]   bden [1];
    logic [cpcl_pkg::BQUO_W-1:0]   bquo [1];
    logic                          b_valid;

    logic [19:0]                   total;
    logic [cpcl_pkg::BUD_W-1:0]    budget;

    logic                          c_valid_reg;
    logic [cpcl_pkg::BUD_W-1:0]    c_budget_reg;
    logic                          c_scaled_reg;
    cpcl_pkg::cmd_vec_t            c_cmds_reg;
    logic [cpcl_pkg::SUM_W-1:0]    c_sum_reg;

    logic                          d_valid_reg;
    logic [cpcl_pkg::LNUM_W-1:0]   d_prod_reg [L];
    logic [cpcl_pkg::LDEN_W-1:0]   d_den_reg  [L];
    cpcl_pkg::lside_t              d_side_reg;

    logic [15:0]                   c_mag [L];
    logic [cpcl_pkg::LQUO_W-1:0]   lquo [L];
    cpcl_pkg::lside_t              lside_out;
    logic                          l_valid;

    logic                          out_valid_reg;
    cpcl_pkg::cmd_vec_t            limited_reg;
    logic                          scaled_reg;
    logic [cpcl_pkg::BUD_W-1:0]    budget_reg;
    cpcl_pkg::cmd_vec_t            limited_next;

    // whole back pipeline moves when the output register can take a word
    assign adv        = !out_valid_reg || out_ready;
    assign item_ready = adv;

    // quotient overflow saturates the budget
    always_comb
    begin
        bside_in.on   = item.on;
        bside_in.ovf  = (cpcl_pkg::BDEN_W'(item.num[cpcl_pkg::BNUM_W-1:cpcl_pkg::BQUO_W])
                         >= item.den);
        bside_in.base = item.base;
        bside_in.cmds = item.cmds;
        bside_in.sum  = item.sum;
        bnum[0] = item.num;
        bden[0] = item.den;
    end

    cpcl_div #(
        .LANES  (1),
        .NUM_W  (cpcl_pkg::BNUM_W),
        .DEN_W  (cpcl_pkg::BDEN_W),
        .QUO_W  (cpcl_pkg::BQUO_W),
        .SIDE_W ($bits(cpcl_pkg::bside_t))
    ) u_budget_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (item_valid),
        .num       (bnum),
        .den       (bden),
        .side      (bside_in),
        .out_valid (b_valid),
        .quo       (bquo),
        .side_out  (bside_out)
    );

    // budget with saturation, zero when the limiter is off
    always_comb
    begin
        total = 20'(bside_out.base) + 20'(bquo[0]);
        if (!bside_out.on)
            budget = '0;
        else if (bside_out.ovf || total > 20'(cpcl_pkg::BUDGET_MAX))
            budget = cpcl_pkg::BUDGET_MAX;
        else
            budget = total[cpcl_pkg::BUD_W-1:0];
    end

    // compare stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_budget_reg <= budget;
            c_scaled_reg <= bside_out.on && (bside_out.sum > budget);
            c_cmds_reg   <= bside_out.cmds;
            c_sum_reg    <= bside_out.sum;
        end
    end

    // product stage
    always_comb
    begin
        for (int k = 0; k < L; k++)
            c_mag[k] = c_cmds_reg[k][15] ? 16'(-c_cmds_reg[k]) : c_cmds_reg[k];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < L; k++)
            begin
                d_prod_reg[k] <= cpcl_pkg::LNUM_W'(c_mag[k]) *
                                 cpcl_pkg::LNUM_W'(c_budget_reg);
                d_den_reg[k]  <= cpcl_pkg::LDEN_W'(c_sum_reg);
            end
            d_side_reg.scaled <= c_scaled_reg;
            d_side_reg.budget <= c_budget_reg;
            d_side_reg.cmds   <= c_cmds_reg;
        end
    end

    cpcl_div #(
        .LANES  (L),
        .NUM_W  (cpcl_pkg::LNUM_W),
        .DEN_W  (cpcl_pkg::LDEN_W),
        .QUO_W  (cpcl_pkg::LQUO_W),
        .SIDE_W ($bits(cpcl_pkg::lside_t))
    ) u_lane_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .num       (d_prod_reg),
        .den       (d_den_reg),
        .side      (d_side_reg),
        .out_valid (l_valid),
        .quo       (lquo),
        .side_out  (lside_out)
    );

    // restore signs or pass through
    always_comb
    begin
        for (int k = 0; k < L; k++)
        begin
            if (!lside_out.scaled)
                limited_next[k] = lside_out.cmds[k];
            else if (lside_out.cmds[k][15])
                limited_next[k] = -$signed({1'b0, lquo[k]});
            else
                limited_next[k] = $signed({1'b0, lquo[k]});
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= l_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            limited_reg <= limited_next;
            scaled_reg  <= lside_out.scaled;
            budget_reg  <= lside_out.budget;
        end
    end

    assign out_valid       = out_valid_reg;
    assign limited         = limited_reg;
    assign scaling_applied = scaled_reg;
    assign current_budget  = budget_reg;

    a_budget_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> budget_reg <= cpcl_pkg::BUDGET_MAX)
        else $error("budget above saturation level");
    a_off_no_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_budget_reg == '0 && c_sum_reg == '0) |-> !c_scaled_reg)
        else $error("scaling flagged with nothing to scale");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(budget_reg))
        else $error("output word dropped while stalled");

endmodule

FILE: rtl/chassis_power_current_limiter.sv
// top level of the chassis power current limiter
//
//  channel  | handshake            | carries
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_ready  | limiter_on, measured_power, buffer_energy,
//           |                      | command_0..3
//  out      | out_valid/ out_ready | limited_0..3, scaling_applied, current_budget
//  cfg      | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// one word accepted per cycle when the output is taken each cycle
// path: front register, queue, 19-stage budget divider,
// compare and product registers, 15-stage lane divider, output register
// reset clears control state and loads the register defaults; no clearing pass
// a stalled output holds the back pipeline; the queue lets the front keep going until it is full
module chassis_power_current_limiter #(
    parameter int MOTOR_LANES = cpcl_pkg::DEF_MOTOR_LANES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cpcl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpcl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              limiter_on,
    input  logic [15:0]                       measured_power,
    input  logic [15:0]                       buffer_energy,
    input  logic signed [15:0]                command_0,
    input  logic signed [15:0]                command_1,
    input  logic signed [15:0]                command_2,
    input  logic signed [15:0]                command_3,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [15:0]                limited_0,
    output logic signed [15:0]                limited_1,
    output logic signed [15:0]                limited_2,
    output logic signed [15:0]                limited_3,
    output logic                              scaling_applied,
    output logic [17:0]                       current_budget
);

    cpcl_pkg::cfg_t     cfg_reg;
    cpcl_pkg::cmd_vec_t cmds;
    cpcl_pkg::cmd_vec_t limited;
    logic               f_valid;
    logic               f_ready;
    cpcl_pkg::item_t    f_item;
    logic               q_valid;
    logic               q_ready;
    cpcl_pkg::item_t    q_item;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warning_buffer        <= 16'd3840;
            cfg_reg.power_knee            <= 16'd2560;
            cfg_reg.power_ceiling         <= 16'd5120;
            cfg_reg.buffer_current_budget <= 17'd16000;
            cfg_reg.power_current_budget  <= 17'd20000;
            cfg_reg.motor_count           <= 3'd4;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cpcl_pkg::REG_WARNING_BUFFER: cfg_reg.warning_buffer <= cfg_data[15:0];
                cpcl_pkg::REG_POWER_KNEE:     cfg_reg.power_knee     <= cfg_data[15:0];
                cpcl_pkg::REG_POWER_CEILING:  cfg_reg.power_ceiling  <= cfg_data[15:0];
                cpcl_pkg::REG_BUFFER_BUDGET:  cfg_reg.buffer_current_budget <= cfg_data;
                cpcl_pkg::REG_POWER_BUDGET:   cfg_reg.power_current_budget  <= cfg_data;
                cpcl_pkg::REG_MOTOR_COUNT:    cfg_reg.motor_count    <= cfg_data[2:0];
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cmds[0] = command_0;
    assign cmds[1] = command_1;
    assign cmds[2] = command_2;
    assign cmds[3] = command_3;

    cpcl_front #(
        .MOTOR_LANES (MOTOR_LANES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .limiter_on     (limiter_on),
        .measured_power (measured_power),
        .buffer_energy  (buffer_energy),
        .cmds           (cmds),
        .item_valid     (f_valid),
        .item_ready     (f_ready),
        .item           (f_item)
    );

    cpcl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_item)
    );

    cpcl_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (q_valid),
        .item_ready      (q_ready),
        .item            (q_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .limited         (limited),
        .scaling_applied (scaling_applied),
        .current_budget  (current_budget)
    );

    assign limited_0 = limited[0];
    assign limited_1 = limited[1];
    assign limited_2 = limited[2];
    assign limited_3 = limited[3];

endmodule

FILE: sim/chassis_power_current_limiter_tb.sv
// self-checking testbench of the chassis power current limiter
module chassis_power_current_limiter_tb;

    typedef struct packed {
        logic        on;
        logic [15:0] power;
        logic [15:0] buffer;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
    } word_t;

    typedef struct packed {
        logic [15:0] l0;
        logic [15:0] l1;
        logic [15:0] l2;
        logic [15:0] l3;
        logic        scaled;
        logic [17:0] budget;
    } limited_t;

    localparam int MOTOR_LANES_USED = cpcl_pkg::DEF_MOTOR_LANES;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [cpcl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cpcl_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic limiter_on;
    logic [15:0] measured_power;
    logic [15:0] buffer_energy;
    logic signed [15:0] command_0, command_1, command_2, command_3;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] limited_0, limited_1, limited_2, limited_3;
    logic scaling_applied;
    logic [17:0] current_budget;

    chassis_power_current_limiter dut (.*);

    // local copy of the registers
    logic [15:0] m_warn_buf, m_warn_pow, m_ceiling;
    logic [16:0] m_buf_bud, m_pow_bud;
    logic [2:0]  m_count;

    word_t    pending_words[$];
    limited_t expected_limits[$];
    int  errors = 0;
    int  checked = 0;
    bit  quiet = 0;
    int  n_scaled = 0;

    // accept flag captured at the rising edge
    logic in_ready_s = 1'b0;

    function automatic logic [17:0] budget_of(input logic [15:0] pw, input logic [15:0] bf);
        longint unsigned b, bud;
        if (bf < m_warn_buf)
        begin
            b = (bf > cpcl_pkg::FLOOR_BUFFER) ? bf : cpcl_pkg::FLOOR_BUFFER;
            bud = (longint'(m_buf_bud) * b) / m_warn_buf;
        end
        else if (pw <= m_warn_pow)
            bud = longint'(m_buf_bud) + m_pow_bud;
        else if (pw < m_ceiling)
            bud = longint'(m_buf_bud)
                + (longint'(m_pow_bud) * (m_ceiling - pw)) / (m_ceiling - m_warn_pow);
        else
            bud = m_buf_bud;
        if (bud > cpcl_pkg::BUDGET_MAX)
            bud = cpcl_pkg::BUDGET_MAX;
        return bud[17:0];
    endfunction

    function automatic limited_t limit_word(input word_t w);
        limited_t r;
        longint cmd[4];
        longint res[4];
        longint unsigned sum, bud, mag, q;
        int n;
        sum = 0;
        bud = 0;
        n = (m_count > MOTOR_LANES_USED) ? MOTOR_LANES_USED : m_count;
        cmd[0] = $signed(w.c0);
        cmd[1] = $signed(w.c1);
        cmd[2] = $signed(w.c2);
        cmd[3] = $signed(w.c3);
        r.scaled = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            res[i] = 0;
            if (i < n)
            begin
                res[i] = cmd[i];
                sum += (cmd[i] < 0) ? -cmd[i] : cmd[i];
            end
        end
        if (w.on)
        begin
            bud = budget_of(w.power, w.buffer);
            if (sum > bud)
            begin
                r.scaled = 1'b1;
                for (int i = 0; i < n; i++)
                begin
                    mag = (cmd[i] < 0) ? -cmd[i] : cmd[i];
                    q = (mag * bud) / sum;
                    res[i] = (cmd[i] < 0) ? -longint'(q) : longint'(q);
                end
            end
        end
        r.l0 = res[0][15:0];
        r.l1 = res[1][15:0];
        r.l2 = res[2][15:0];
        r.l3 = res[3][15:0];
        r.budget = bud[17:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if ((!in_valid || in_ready_s) && rst_n)
        begin
            if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 22))
            begin
                word_t w;
                w = pending_words.pop_front();
                expected_limits.push_back(limit_word(w));
                in_valid <= 1'b1;
                limiter_on <= w.on;
                measured_power <= w.power;
                buffer_energy <= w.buffer;
                command_0 <= w.c0;
                command_1 <= w.c1;
                command_2 <= w.c2;
                command_3 <= w.c3;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= quiet || ($urandom_range(99) >= 22);
    end

    always @(posedge clk)
        in_ready_s <= in_valid && in_ready;

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_limits.size() == 0)
                report("unexpected word", 0, 0);
            else
            begin
                limited_t e;
                e = expected_limits.pop_front();
                checked++;
                if (e.scaled)
                    n_scaled++;
                if (limited_0 !== e.l0) report("limited_0", limited_0, e.l0);
                if (limited_1 !== e.l1) report("limited_1", limited_1, e.l1);
                if (limited_2 !== e.l2) report("limited_2", limited_2, e.l2);
                if (limited_3 !== e.l3) report("limited_3", limited_3, e.l3);
                if (scaling_applied !== e.scaled)
                    report("scaling_applied", scaling_applied, e.scaled);
                if (current_budget !== e.budget)
                    report("current_budget", current_budget, e.budget);
            end
        end
    end

    task automatic write_reg(input logic [cpcl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cpcl_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            cpcl_pkg::REG_WARNING_BUFFER: m_warn_buf = val[15:0];
            cpcl_pkg::REG_POWER_KNEE:     m_warn_pow = val[15:0];
            cpcl_pkg::REG_POWER_CEILING:  m_ceiling = val[15:0];
            cpcl_pkg::REG_BUFFER_BUDGET:  m_buf_bud = val;
            cpcl_pkg::REG_POWER_BUDGET:   m_pow_bud = val;
            cpcl_pkg::REG_MOTOR_COUNT:    m_count = val[2:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !in_valid && expected_limits.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_cmd();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic word_t rand_word();
        word_t w;
        w.on = ($urandom_range(9) != 0);
        w.power = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8000));
        w.buffer = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6000));
        w.c0 = rand_cmd();
        w.c1 = rand_cmd();
        w.c2 = rand_cmd();
        w.c3 = rand_cmd();
        return w;
    endfunction

    // stimulus
    initial
    begin
        word_t w;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        limiter_on = 1'b0;
        measured_power = '0;
        buffer_energy = '0;
        command_0 = '0;
        command_1 = '0;
        command_2 = '0;
        command_3 = '0;
        m_warn_buf = 16'd3840;
        m_warn_pow = 16'd2560;
        m_ceiling = 16'd5120;
        m_buf_bud = 17'd16000;
        m_pow_bud = 17'd20000;
        m_count = 3'd4;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words at reset settings: off, buffer low and floored,
        // power inside and above the window, extreme commands
        w = '{1'b0, 16'd0, 16'd0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        pending_words.push_back(w);
        w = '{1'b1, 16'd0, 16'd0, 16'h8000, 16'h7fff, 16'h0001, 16'hffff};
        pending_words.push_back(w);
        w = '{1'b1, 16'd100, 16'd2000, 16'h1000, 16'hf000, 16'h0100, 16'h0000};
        pending_words.push_back(w);
        w = '{1'b1, 16'd2560, 16'd3840, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        pending_words.push_back(w);
        w = '{1'b1, 16'd4000, 16'hffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
        pending_words.push_back(w);
        w = '{1'b1, 16'hffff, 16'hffff, 16'h0010, 16'hfff0, 16'h0003, 16'h0000};
        pending_words.push_back(w);
        w = '{1'b1, 16'd5120, 16'd5000, 16'h2000, 16'h2000, 16'h2000, 16'h2000};
        pending_words.push_back(w);
        drain();

        // small warning level, ceiling below warning power, lane counts, then random settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(cpcl_pkg::REG_WARNING_BUFFER, 17'd321);
                    write_reg(cpcl_pkg::REG_BUFFER_BUDGET, 17'h1ffff);
                    write_reg(cpcl_pkg::REG_POWER_BUDGET, 17'h1ffff);
                    write_reg(cpcl_pkg::REG_MOTOR_COUNT, 17'd0);
                end
                1:
                begin
                    write_reg(cpcl_pkg::REG_POWER_KNEE, 17'd3000);
                    write_reg(cpcl_pkg::REG_POWER_CEILING, 17'd1000);
                    write_reg(cpcl_pkg::REG_MOTOR_COUNT, 17'd7);
                    write_reg(cpcl_pkg::REG_BUFFER_BUDGET, 17'd0);
                end
                2:
                begin
                    write_reg(cpcl_pkg::REG_WARNING_BUFFER, 17'hffff);
                    write_reg(cpcl_pkg::REG_POWER_KNEE, 17'd0);
                    write_reg(cpcl_pkg::REG_POWER_CEILING, 17'hffff);
                    write_reg(cpcl_pkg::REG_POWER_BUDGET, 17'd0);
                    write_reg(cpcl_pkg::REG_MOTOR_COUNT, 17'd1);
                end
                3:
                begin
                    write_reg(cpcl_pkg::REG_WARNING_BUFFER, 17'd2000);
                    write_reg(cpcl_pkg::REG_POWER_KNEE, 17'hffff);
                    write_reg(cpcl_pkg::REG_POWER_CEILING, 17'd0);
                    write_reg(cpcl_pkg::REG_BUFFER_BUDGET, 17'd40000);
                    write_reg(cpcl_pkg::REG_MOTOR_COUNT, 17'd2);
                end
                default:
                begin
                    write_reg(cpcl_pkg::REG_WARNING_BUFFER, 17'($urandom_range(65535, 321)));
                    write_reg(cpcl_pkg::REG_POWER_KNEE, 17'($urandom_range(6000)));
                    write_reg(cpcl_pkg::REG_POWER_CEILING, 17'($urandom_range(9000)));
                    write_reg(cpcl_pkg::REG_BUFFER_BUDGET, 17'($urandom_range(131071)));
                    write_reg(cpcl_pkg::REG_POWER_BUDGET, 17'($urandom_range(131071)));
                    write_reg(cpcl_pkg::REG_MOTOR_COUNT, 17'($urandom_range(4, 1)));
                end
            endcase
            quiet = (ph == 5);
            for (int i = 0; i < 140; i++)
                pending_words.push_back(rand_word());
            drain();
        end
        $display("checked %0d limited words over 9 register settings, %0d scaled",
            checked, n_scaled);
        if (errors == 0)
            $display("chassis_power_current_limiter regression: pass");
        else
            $display("chassis_power_current_limiter regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("chassis_power_current_limiter regression: fail");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/cpcl_pkg.sv
rtl/cpcl_front.sv
rtl/cpcl_queue.sv
rtl/cpcl_div.sv
rtl/cpcl_back.sv
rtl/chassis_power_current_limiter.sv
sim/chassis_power_current_limiter_tb.sv
